@@ src/ecs_pkg.sv @@
`timescale 1ns / 1ps
package ecs_pkg;

    localparam int unsigned POS_W  = 48;
    localparam int unsigned MASS_W = 32;
    localparam int unsigned MAG_W  = 49;
    localparam int unsigned EXT_W  = 50;
    localparam int unsigned COEF_W = 33;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 48;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_RUN  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTITUTION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTACT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE      = 3'd5;

    localparam logic signed [EXT_W-1:0] SMAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [EXT_W-1:0] SMIN = -50'sh0_8000_0000_0000;

    typedef struct packed {
        logic [1:0]               action;
        logic [3:0]               object_index;
        logic signed [POS_W-1:0]  position;
        logic signed [POS_W-1:0]  velocity;
        logic [MASS_W-1:0]        mass;
        logic [16:0]              substeps;
    } t_item;

    typedef struct packed {
        logic [3:0]               index_out;
        logic signed [POS_W-1:0]  position_out;
        logic signed [POS_W-1:0]  velocity_out;
        logic [31:0]              collision_count;
    } t_result;

    typedef enum logic [1:0] {
        OP_MUL16,
        OP_MUL31,
        OP_MUL32,
        OP_DIV
    } t_alu_op;

    typedef struct packed {
        logic               go;
        t_alu_op            op;
        logic [MAG_W-1:0]   a;
        logic [COEF_W-1:0]  b;
    } t_alu_req;

    typedef struct packed {
        logic               done;
        logic [MAG_W-1:0]   res;
    } t_alu_rsp;

    function automatic logic signed [POS_W-1:0] sat48(input logic signed [EXT_W-1:0] x);
        logic signed [EXT_W-1:0] y;
        y = x;
        if (x > SMAX) y = SMAX;
        if (x < SMIN) y = SMIN;
        return y[POS_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic signed [EXT_W-1:0] x);
        logic signed [EXT_W-1:0] t;
        t = (x < 0) ? -x : x;
        return t[MAG_W-1:0];
    endfunction

    function automatic logic signed [EXT_W-1:0] with_sign(input logic [MAG_W-1:0] m,
                                                          input logic neg);
        logic signed [EXT_W-1:0] t;
        t = $signed({1'b0, m});
        return neg ? -t : t;
    endfunction

endpackage

@@ src/ecs_ram.sv @@
`timescale 1ns / 1ps
module ecs_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/ecs_alu.sv @@
`timescale 1ns / 1ps
module ecs_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ecs_pkg::t_alu_req i_req,
    output ecs_pkg::t_alu_rsp o_rsp
);
    import ecs_pkg::*;

    typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} t_state;

    t_state            r_state;
    t_alu_op           r_op;
    logic [6:0]        r_cnt;
    logic [MAG_W-1:0]  r_a;
    logic [COEF_W-1:0] r_b;
    logic [81:0]       r_acc;
    logic [63:0]       r_num;
    logic [32:0]       r_rem;
    logic [32:0]       r_q;
    logic [MAG_W-1:0]  r_res;
    logic              r_done;

    logic [33:0] trial;
    logic        fits;
    logic [81:0] shifted;

    always_comb begin
        trial = {r_rem, r_num[63]};
        fits  = trial >= {1'b0, r_b};
        case (r_op)
            OP_MUL16: shifted = r_acc >> 16;
            OP_MUL31: shifted = r_acc >> 31;
            default:  shifted = r_acc >> 32;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.go) begin
                        r_op <= i_req.op;
                        r_a  <= i_req.a;
                        r_b  <= i_req.b;
                        if (i_req.op == OP_DIV) begin
                            r_num   <= {i_req.a[31:0], 32'd0};
                            r_rem   <= '0;
                            r_q     <= '0;
                            r_cnt   <= 7'd63;
                            r_state <= A_DIV;
                        end else begin
                            r_acc   <= '0;
                            r_cnt   <= 7'd32;
                            r_state <= A_MUL;
                        end
                    end
                end
                A_MUL: begin
                    r_acc <= (r_acc << 1) + (r_b[COEF_W-1] ? 82'(r_a) : 82'd0);
                    r_b   <= r_b << 1;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd0) r_state <= A_FIN;
                end
                A_DIV: begin
                    if (fits) begin
                        r_rem <= 33'(trial - {1'b0, r_b});
                        r_q   <= {r_q[31:0], 1'b1};
                    end else begin
                        r_rem <= trial[32:0];
                        r_q   <= {r_q[31:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd0) r_state <= A_FIN;
                end
                A_FIN: begin
                    if (r_op == OP_DIV) begin
                        r_res <= MAG_W'(r_q);
                    end else if (shifted > (82'd1 << 48)) begin
                        r_res <= MAG_W'(82'd1 << 48);
                    end else begin
                        r_res <= shifted[MAG_W-1:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
endmodule

@@ src/elastic_collision_step_1d.sv @@
`timescale 1ns / 1ps
// channel   | ports                              | handshake
// ----------+------------------------------------+-------------------------------
// command   | i_start, i_item, o_busy            | taken when i_start && !o_busy
// result    | o_strobe, o_result                 | one-cycle strobe, no back-pressure
// config    | i_cfg_we, i_cfg_idx, i_cfg_data    | written on any edge with i_cfg_we
//
// after a load is taken o_strobe follows the store write, read and capture states; a
// read skips the write; run visits per substep each object (gravity, move, wall bounce),
// each pair (contact check, two divides and two multiplies on a hit), then ends the substep
// run time is set by the shared alu, which takes one multiply or divide at a time,
// and by the single read port of the object store, one entry per access
// synchronous active-low reset clears control and the entry valid bits and restores the config defaults
// the result cannot be stalled; o_busy stays high until the result transaction
module elastic_collision_step_1d #(
    parameter int MAX_OBJECTS = 16,
    parameter int FRAC_BITS   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  ecs_pkg::t_item                    i_item,
    output logic                              o_busy,
    output logic                              o_strobe,
    output ecs_pkg::t_result                  o_result,
    input  logic                              i_cfg_we,
    input  logic [ecs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ecs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ecs_pkg::*;

    localparam int AW = $clog2(MAX_OBJECTS);
    localparam int CW = $clog2(MAX_OBJECTS + 1);
    localparam int ENT_W = MASS_W + 2 * POS_W;
    // reset wall: 199 in fixed point, clipped to the 47-bit field
    localparam logic [63:0] WALL_FULL = 64'd199 << FRAC_BITS;
    localparam logic [46:0] WALL_RST  = (WALL_FULL > 64'h7FFF_FFFF_FFFF) ?
                                        47'h7FFF_FFFF_FFFF : WALL_FULL[46:0];
    localparam logic [46:0] CONTACT_RST = 47'(64'd1 << (FRAC_BITS - 1));

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD_WR, S_OUT_RD, S_OUT_CAP,
        S_ST_RD, S_ST_LD, S_ST_MUL, S_ST_BNC, S_ST_WR,
        S_PR_RDI, S_PR_LDI, S_PR_RDJ, S_PR_LDJ, S_PR_CHK,
        S_PR_D1, S_PR_D2, S_PR_M1, S_PR_M2, S_PR_WRI, S_PR_WRJ,
        S_PR_NEXT, S_STEP_END
    } t_state;

    // configuration
    logic [31:0]             r_dt;
    logic [46:0]             r_wall;
    logic [16:0]             r_rest;
    logic signed [POS_W-1:0] r_grav;
    logic [46:0]             r_contact;
    logic [4:0]              r_active;

    t_state                  r_state;
    logic [3:0]              r_idx;
    logic                    r_idx_ok;
    logic [16:0]             r_steps;
    logic [CW-1:0]           r_n;
    logic [CW-1:0]           r_i;
    logic [CW-1:0]           r_j;
    logic [AW-1:0]           r_addr;
    logic [31:0]             r_count;
    logic [MAX_OBJECTS-1:0]  r_vld;
    logic                    r_rd_vld;

    // working copies of the pair (object pass and load use the i set)
    logic signed [POS_W-1:0] r_pi, r_vi, r_pj, r_vj;
    logic [MASS_W-1:0]       r_mi, r_mj;
    logic [MAG_W-1:0]        r_ur;
    logic                    r_rel_neg;
    logic [COEF_W-1:0]       r_total, r_f1;

    t_alu_req                r_req;
    t_alu_rsp                alu_rsp;
    logic                    r_strobe;
    t_result                 r_result;

    // store access
    logic                    we;
    logic [AW-1:0]           waddr;
    logic [ENT_W-1:0]        wdata;
    logic [ENT_W-1:0]        rdata;
    logic signed [POS_W-1:0] e_p, e_v;
    logic [MASS_W-1:0]       e_m;

    // datapath helpers
    logic                    idx_ok;
    logic [CW-1:0]           n_active;
    logic [CW:0]             i1, i2, j1;
    logic signed [EXT_W-1:0] v_grav, p_new, sep, rel;
    logic [COEF_W-1:0]       total;
    logic                    hit_pair;

    ecs_ram #(.WIDTH(ENT_W), .DEPTH(MAX_OBJECTS)) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(r_addr),
        .o_rdata(rdata)
    );

    ecs_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_req),
        .o_rsp  (alu_rsp)
    );

    // entries never written read as zero
    assign e_p = r_rd_vld ? $signed(rdata[POS_W-1:0]) : '0;
    assign e_v = r_rd_vld ? $signed(rdata[2*POS_W-1:POS_W]) : '0;
    assign e_m = r_rd_vld ? rdata[ENT_W-1:2*POS_W] : '0;

    always_comb begin
        we    = 1'b0;
        waddr = r_i[AW-1:0];
        wdata = {r_mi, r_vi, r_pi};
        unique case (r_state)
            // load data was captured with the command
            S_LOAD_WR: begin
                we    = r_idx_ok;
                waddr = r_addr;
            end
            S_ST_WR, S_PR_WRI: we = 1'b1;
            S_PR_WRJ: begin
                we    = 1'b1;
                waddr = r_j[AW-1:0];
                wdata = {r_mj, r_vj, r_pj};
            end
            default: we = 1'b0;
        endcase
    end

    always_comb begin
        idx_ok   = 32'(i_item.object_index) < MAX_OBJECTS;
        n_active = (32'(r_active) > MAX_OBJECTS) ? CW'(MAX_OBJECTS) : CW'(r_active);
        i1       = {1'b0, r_i} + 1'b1;
        i2       = {1'b0, r_i} + 2'd2;
        j1       = {1'b0, r_j} + 1'b1;
        v_grav   = EXT_W'(e_v) + EXT_W'(r_grav);
        p_new    = EXT_W'(r_pi) + with_sign(alu_rsp.res, r_vi < 0);
        sep      = EXT_W'(r_pi) - EXT_W'(r_pj);
        rel      = EXT_W'(r_vi) - EXT_W'(r_vj);
        total    = COEF_W'(r_mi) + COEF_W'(r_mj);
        // in contact, approaching, and a usable mass sum
        hit_pair = (mag(sep) <= {2'b00, r_contact}) &&
                   ((rel < 0 && sep > 0) || (rel > 0 && sep < 0)) &&
                   (total != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_strobe  <= 1'b0;
            r_req.go  <= 1'b0;
            r_count   <= '0;
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_dt      <= 32'd42950;
            r_wall    <= WALL_RST;
            r_rest    <= 17'h10000;
            r_grav    <= '0;
            r_contact <= CONTACT_RST;
            r_active  <= 5'd2;
        end else begin
            r_strobe <= 1'b0;
            r_req.go <= 1'b0;
            r_rd_vld <= r_vld[r_addr];
            if (we) r_vld[waddr] <= 1'b1;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TIME_STEP:   r_dt      <= i_cfg_data[31:0];
                    CFG_WALL:        r_wall    <= i_cfg_data[46:0];
                    CFG_RESTITUTION: r_rest    <= i_cfg_data[16:0];
                    CFG_GRAVITY:     r_grav    <= $signed(i_cfg_data);
                    CFG_CONTACT:     r_contact <= i_cfg_data[46:0];
                    CFG_ACTIVE:      r_active  <= i_cfg_data[4:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_idx    <= i_item.object_index;
                        r_idx_ok <= idx_ok;
                        r_addr   <= AW'(i_item.object_index);
                        r_n      <= n_active;
                        r_steps  <= i_item.substeps;
                        r_i      <= '0;
                        // the command may change once taken
                        r_pi     <= i_item.position;
                        r_vi     <= i_item.velocity;
                        r_mi     <= i_item.mass;
                        if (i_item.action == ACT_LOAD) begin
                            r_state <= S_LOAD_WR;
                        end else if (i_item.action == ACT_RUN && i_item.substeps != '0 &&
                                     n_active != '0) begin
                            r_addr  <= '0;
                            r_state <= S_ST_RD;
                        end else begin
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                S_LOAD_WR: r_state <= S_OUT_RD;
                S_OUT_RD:  r_state <= S_OUT_CAP;
                S_OUT_CAP: begin
                    r_result.index_out       <= r_idx;
                    r_result.position_out    <= r_idx_ok ? e_p : '0;
                    r_result.velocity_out    <= r_idx_ok ? e_v : '0;
                    r_result.collision_count <= r_count;
                    r_strobe                 <= 1'b1;
                    r_state                  <= S_IDLE;
                end

                // object pass: gravity, move, walls
                S_ST_RD: r_state <= S_ST_LD;
                S_ST_LD: begin
                    r_vi     <= sat48(v_grav);
                    r_pi     <= e_p;
                    r_mi     <= e_m;
                    r_req.go <= 1'b1;
                    r_req.op <= OP_MUL32;
                    r_req.a  <= mag(EXT_W'(sat48(v_grav)));
                    r_req.b  <= COEF_W'(r_dt);
                    r_state  <= S_ST_MUL;
                end
                S_ST_MUL: begin
                    if (alu_rsp.done) begin
                        r_req.op <= OP_MUL16;
                        r_req.a  <= mag(EXT_W'(r_vi));
                        r_req.b  <= COEF_W'(r_rest);
                        if (sat48(p_new) <= 0) begin
                            r_count  <= r_count + 1'b1;
                            r_pi     <= '0;
                            r_req.go <= 1'b1;
                            r_state  <= S_ST_BNC;
                        end else if (EXT_W'(sat48(p_new)) >= $signed({3'b000, r_wall})) begin
                            r_count  <= r_count + 1'b1;
                            r_pi     <= $signed({1'b0, r_wall});
                            r_req.go <= 1'b1;
                            r_state  <= S_ST_BNC;
                        end else begin
                            r_pi    <= sat48(p_new);
                            r_state <= S_ST_WR;
                        end
                    end
                end
                S_ST_BNC: begin
                    if (alu_rsp.done) begin
                        r_vi    <= sat48(with_sign(alu_rsp.res, r_vi > 0));
                        r_state <= S_ST_WR;
                    end
                end
                S_ST_WR: begin
                    if (i1 == {1'b0, r_n}) begin
                        r_i <= '0;
                        r_j <= CW'(1);
                        r_addr <= '0;
                        r_state <= (r_n >= CW'(2)) ? S_PR_RDI : S_STEP_END;
                    end else begin
                        r_i     <= i1[CW-1:0];
                        r_addr  <= i1[AW-1:0];
                        r_state <= S_ST_RD;
                    end
                end

                // pair pass
                S_PR_RDI: r_state <= S_PR_LDI;
                S_PR_LDI: begin
                    r_pi    <= e_p;
                    r_vi    <= e_v;
                    r_mi    <= e_m;
                    r_addr  <= r_j[AW-1:0];
                    r_state <= S_PR_RDJ;
                end
                S_PR_RDJ: r_state <= S_PR_LDJ;
                S_PR_LDJ: begin
                    r_pj    <= e_p;
                    r_vj    <= e_v;
                    r_mj    <= e_m;
                    r_state <= S_PR_CHK;
                end
                S_PR_CHK: begin
                    r_ur      <= mag(rel);
                    r_rel_neg <= rel < 0;
                    r_total   <= total;
                    if (hit_pair) begin
                        r_count  <= r_count + 1'b1;
                        r_req.go <= 1'b1;
                        r_req.op <= OP_DIV;
                        r_req.a  <= MAG_W'(r_mi);
                        r_req.b  <= total;
                        r_state  <= S_PR_D1;
                    end else begin
                        r_state <= S_PR_NEXT;
                    end
                end
                S_PR_D1: begin
                    if (alu_rsp.done) begin
                        r_f1     <= alu_rsp.res[COEF_W-1:0];
                        r_req.go <= 1'b1;
                        r_req.op <= OP_DIV;
                        r_req.a  <= MAG_W'(r_mj);
                        r_req.b  <= r_total;
                        r_state  <= S_PR_D2;
                    end
                end
                S_PR_D2: begin
                    if (alu_rsp.done) begin
                        r_req.go <= 1'b1;
                        r_req.op <= OP_MUL31;
                        r_req.a  <= r_ur;
                        r_req.b  <= alu_rsp.res[COEF_W-1:0];
                        r_state  <= S_PR_M1;
                    end
                end
                S_PR_M1: begin
                    if (alu_rsp.done) begin
                        r_vi     <= sat48(EXT_W'(r_vi) - with_sign(alu_rsp.res, r_rel_neg));
                        r_req.go <= 1'b1;
                        r_req.op <= OP_MUL31;
                        r_req.a  <= r_ur;
                        r_req.b  <= r_f1;
                        r_state  <= S_PR_M2;
                    end
                end
                S_PR_M2: begin
                    if (alu_rsp.done) begin
                        r_vj    <= sat48(EXT_W'(r_vj) + with_sign(alu_rsp.res, r_rel_neg));
                        r_state <= S_PR_WRI;
                    end
                end
                S_PR_WRI: r_state <= S_PR_WRJ;
                S_PR_WRJ: r_state <= S_PR_NEXT;
                S_PR_NEXT: begin
                    if (j1 < {1'b0, r_n}) begin
                        r_j     <= j1[CW-1:0];
                        r_addr  <= r_i[AW-1:0];
                        r_state <= S_PR_RDI;
                    end else if (i2 < {1'b0, r_n}) begin
                        r_i     <= i1[CW-1:0];
                        r_j     <= i2[CW-1:0];
                        r_addr  <= i1[AW-1:0];
                        r_state <= S_PR_RDI;
                    end else begin
                        r_state <= S_STEP_END;
                    end
                end
                S_STEP_END: begin
                    if (r_steps == 17'd1) begin
                        r_addr  <= AW'(r_idx);
                        r_state <= S_OUT_RD;
                    end else begin
                        r_steps <= r_steps - 1'b1;
                        r_i     <= '0;
                        r_addr  <= '0;
                        r_state <= S_ST_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // a result transaction only leaves once the command is finished
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !o_busy) else $error("result while busy");

    // an accepted command holds the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("command not taken");

    // the object store is only written while a command is in flight
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> o_busy) else $error("store written while idle");

    // the alu is never started while it still reports a finished operation
    a_alu_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req.go |-> !alu_rsp.done) else $error("alu restarted early");
endmodule

@@ tb/sv/elastic_collision_step_1d_tb.sv @@
`timescale 1ns / 1ps
module elastic_collision_step_1d_tb;
    import ecs_pkg::*;

    localparam int  NOBJ        = 16;
    localparam int  CYCLE_LIMIT = 30_000_000;
    localparam longint SMAX48   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SMIN48   = -SMAX48 - 1;
    localparam longint unsigned MAG_LIMIT = 64'h0001_0000_0000_0000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    t_item                 i_item = '0;
    logic                  o_busy;
    logic                  o_strobe;
    t_result               o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    elastic_collision_step_1d dut (.*);

    always #2 i_clk = ~i_clk;

    // one entry of the driver's queue: either a command transaction or a register write
    typedef struct {
        bit                    is_cfg;
        t_item                 item;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        int                    gap;
    } t_pending;

    t_pending pending_q[$];
    t_result  expected_q[$];

    // shadow copy of the object store, counter and registers
    longint      pos_st[NOBJ];
    longint      vel_st[NOBJ];
    int unsigned mass_st[NOBJ];
    int unsigned hits;
    longint unsigned dt_reg, wall_reg, rest_reg, contact_reg;
    longint      grav_reg;
    int unsigned active_reg;

    int  errors = 0;
    int  n_results = 0, n_loads = 0, n_runs = 0, n_reads = 0, n_cfg = 0;
    int  cycles = 0;
    int  gap_left = 0;
    bit  burst = 0;

    // ---------------------------------------------------------------- arithmetic

    function automatic longint clamp48(longint x);
        if (x > SMAX48) return SMAX48;
        if (x < SMIN48) return SMIN48;
        return x;
    endfunction

    function automatic longint unsigned abs_mag(longint x);
        return x < 0 ? -x : x;
    endfunction

    // magnitude with a sign put back on, magnitude capped at 2^48
    function automatic longint signed_mag(longint unsigned m, bit neg);
        longint t;
        if (m > MAG_LIMIT) m = MAG_LIMIT;
        t = longint'(m);
        return neg ? -t : t;
    endfunction

    // truncating fixed point product, capped at 2^48
    function automatic longint unsigned scaled_product(longint unsigned a, longint unsigned b,
                                                       int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> sh;
        if (p > MAG_LIMIT) return MAG_LIMIT;
        return p[63:0];
    endfunction

    function automatic longint wall_bounce(longint v);
        return clamp48(signed_mag(scaled_product(abs_mag(v), rest_reg, 16), v > 0));
    endfunction

    function automatic void collide_pair(int i, int j);
        longint sep, rel;
        longint unsigned total, f1, f2, ur;
        sep = pos_st[i] - pos_st[j];
        rel = vel_st[i] - vel_st[j];
        if (abs_mag(sep) > contact_reg) return;
        if (!((rel < 0 && sep > 0) || (rel > 0 && sep < 0))) return;
        total = longint'(mass_st[i]) + longint'(mass_st[j]);
        // zero mass sum: pair left alone and not counted
        if (total == 0) return;
        hits++;
        f1 = (longint'(mass_st[i]) << 32) / total;
        f2 = (longint'(mass_st[j]) << 32) / total;
        ur = abs_mag(rel);
        vel_st[i] = clamp48(vel_st[i] - signed_mag(scaled_product(ur, f2, 31), rel < 0));
        vel_st[j] = clamp48(vel_st[j] + signed_mag(scaled_product(ur, f1, 31), rel < 0));
    endfunction

    function automatic void advance_substep(int n);
        longint v, p;
        for (int i = 0; i < n; i++) begin
            v = clamp48(vel_st[i] + grav_reg);
            p = clamp48(pos_st[i] + signed_mag(scaled_product(abs_mag(v), dt_reg, 32), v < 0));
            // lower wall has priority over the upper one
            if (p <= 0) begin
                hits++;
                v = wall_bounce(v);
                p = 0;
            end else if (p >= longint'(wall_reg)) begin
                hits++;
                v = wall_bounce(v);
                p = longint'(wall_reg);
            end
            vel_st[i] = v;
            pos_st[i] = p;
        end
        for (int i = 0; i + 1 < n; i++)
            for (int j = i + 1; j < n; j++)
                collide_pair(i, j);
    endfunction

    function automatic t_result object_state_after(t_item it);
        t_result r;
        int n;
        case (it.action)
            ACT_LOAD: begin
                pos_st[it.object_index]  = longint'(it.position);
                vel_st[it.object_index]  = longint'(it.velocity);
                mass_st[it.object_index] = it.mass;
                n_loads++;
            end
            ACT_RUN: begin
                // active counts above the store size act as the full store
                n = active_reg > NOBJ ? NOBJ : active_reg;
                for (int s = 0; s < it.substeps; s++) advance_substep(n);
                n_runs++;
            end
            default: n_reads++;   // the unused code reads too
        endcase
        r.index_out       = it.object_index;
        r.position_out    = pos_st[it.object_index][47:0];
        r.velocity_out    = vel_st[it.object_index][47:0];
        r.collision_count = hits;
        return r;
    endfunction

    function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_TIME_STEP:   dt_reg      = d[31:0];
            CFG_WALL:        wall_reg    = d[46:0];
            CFG_RESTITUTION: rest_reg    = d[16:0];
            CFG_GRAVITY:     grav_reg    = longint'($signed(d[47:0]));
            CFG_CONTACT:     contact_reg = d[46:0];
            CFG_ACTIVE:      active_reg  = d[4:0];
            default: ;
        endcase
        n_cfg++;
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        t_pending e;
        bit take, nxt_start, nxt_we;
        if (!i_rst_n) begin
            i_start  <= 1'b0;
            i_cfg_we <= 1'b0;
            gap_left = 0;
        end else begin
            take = i_start && !o_busy;
            if (take) expected_q.push_back(object_state_after(i_item));
            nxt_start = i_start && !take;
            nxt_we = 1'b0;
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() > 0) begin
                    if (pending_q[0].is_cfg) begin
                        // registers only change with nothing in flight
                        if (!take && !o_busy && !i_cfg_we && expected_q.size() == 0) begin
                            e = pending_q.pop_front();
                            shadow_write(e.idx, e.data);
                            i_cfg_idx  <= e.idx;
                            i_cfg_data <= e.data;
                            nxt_we = 1'b1;
                        end
                    end else begin
                        e = pending_q.pop_front();
                        i_item   <= e.item;
                        nxt_start = 1'b1;
                        gap_left  = e.gap;
                    end
                end
            end
            i_start  <= nxt_start;
            i_cfg_we <= nxt_we;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        t_result x;
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (expected_q.size() == 0) begin
                $error("result transaction with nothing expected: %p", o_result);
                errors++;
            end else begin
                x = expected_q.pop_front();
                if (o_result.index_out !== x.index_out) begin
                    $error("index_out exp %0d got %0d", x.index_out, o_result.index_out);
                    errors++;
                end
                if (o_result.position_out !== x.position_out) begin
                    $error("position_out exp %h got %h", x.position_out, o_result.position_out);
                    errors++;
                end
                if (o_result.velocity_out !== x.velocity_out) begin
                    $error("velocity_out exp %h got %h", x.velocity_out, o_result.velocity_out);
                    errors++;
                end
                if (o_result.collision_count !== x.collision_count) begin
                    $error("collision_count exp %0d got %0d", x.collision_count,
                           o_result.collision_count);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("elastic_collision_step_1d_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic longint fx(longint whole);
        return whole <<< 32;
    endfunction

    function automatic longint rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return longint'($signed(r[47:0]));
    endfunction

    task automatic add_item(logic [1:0] act, int idx, longint p, longint v,
                            int unsigned m, int steps);
        t_pending e;
        e.is_cfg = 0;
        e.item.action       = act;
        e.item.object_index = idx[3:0];
        e.item.position     = p[47:0];
        e.item.velocity     = v[47:0];
        e.item.mass         = m;
        e.item.substeps     = steps[16:0];
        e.gap = burst ? 0 : $urandom_range(0, 6);
        pending_q.push_back(e);
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, longint d);
        t_pending e;
        e.is_cfg = 1;
        e.item   = '0;
        e.idx    = idx;
        e.data   = d[47:0];
        e.gap    = 0;
        pending_q.push_back(e);
    endtask

    // random well-formed traffic around the current register setting
    task automatic random_phase(int count, int n_obj, int wall_units);
        t_pending e;
        int sel;
        longint v;
        logic [159:0] raw;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 9);
            if (sel <= 3) begin
                v = ($urandom_range(0, 60) <<< 32) | $urandom;
                if ($urandom_range(0, 1)) v = -v;
                add_item(ACT_LOAD, $urandom_range(0, n_obj - 1),
                         fx($urandom_range(0, wall_units)) | $urandom, v,
                         $urandom_range(0, 3) == 0 ? 0 : $urandom, 0);
            end else if (sel <= 6) begin
                add_item(ACT_RUN, $urandom_range(0, 15), rand48(), rand48(), $urandom,
                         $urandom_range(1, 4));
            end else if (sel <= 8) begin
                add_item($urandom_range(0, 1) ? ACT_READ : 2'd3, $urandom_range(0, 15),
                         rand48(), rand48(), $urandom, $urandom);
            end else begin
                // noise: every field random, long runs kept short
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
                e.item = raw[$bits(t_item)-1:0];
                if (e.item.action == ACT_RUN) e.item.substeps &= 17'd7;
                add_item(e.item.action, e.item.object_index, e.item.position,
                         e.item.velocity, e.item.mass, e.item.substeps);
            end
            if (k % 8 == 7) burst = ~burst;
        end
    endtask

    initial begin
        int n_obj, wall_units;
        for (int i = 0; i < NOBJ; i++) begin
            pos_st[i] = 0;
            vel_st[i] = 0;
            mass_st[i] = 0;
        end
        hits        = 0;
        dt_reg      = 42950;
        wall_reg    = 64'd199 << 32;
        rest_reg    = 65536;
        grav_reg    = 0;
        contact_reg = 64'h8000_0000;
        active_reg  = 2;

        // directed: head-on pair collision under reset settings
        add_item(ACT_LOAD, 0, fx(10), fx(5), 32'h0001_0000, 0);
        add_item(ACT_LOAD, 1, fx(10) + 64'h4000_0000, -fx(5), 32'h0003_0000, 0);
        add_item(ACT_RUN, 0, 0, 0, 0, 1);
        add_item(ACT_READ, 1, 0, 0, 0, 0);
        // field extremes, unused action reads back
        add_item(ACT_LOAD, 15, SMAX48, SMIN48, 32'hFFFF_FFFF, 17'h1FFFF);
        add_item(2'd3, 15, 0, 0, 0, 0);
        add_item(ACT_LOAD, 2, SMIN48, SMAX48, 0, 0);
        add_item(ACT_READ, 2, 0, 0, 0, 0);
        // zero wall hit and a massless pair that must be skipped
        add_item(ACT_LOAD, 0, 1, -fx(3), 0, 0);
        add_item(ACT_LOAD, 1, 2, fx(-1), 0, 0);
        add_item(ACT_RUN, 1, 0, 0, 0, 0);
        add_item(ACT_RUN, 0, 0, 0, 0, 3);
        // extreme registers: whole store, largest dt, no bounce, strong pull down
        add_cfg(CFG_ACTIVE, 16);
        add_cfg(CFG_TIME_STEP, 64'hFFFF_FFFF);
        add_cfg(CFG_RESTITUTION, 0);
        add_cfg(CFG_GRAVITY, SMIN48);
        add_cfg(CFG_CONTACT, 64'h7FFF_FFFF_FFFF);
        add_cfg(CFG_WALL, 0);
        add_item(ACT_RUN, 15, 0, 0, 0, 2);
        add_item(ACT_READ, 2, 0, 0, 0, 0);
        // opposite extremes, active count above the store size
        add_cfg(CFG_ACTIVE, 31);
        add_cfg(CFG_RESTITUTION, 17'h1FFFF);
        add_cfg(CFG_GRAVITY, SMAX48);
        add_cfg(CFG_WALL, 64'h7FFF_FFFF_FFFF);
        add_item(ACT_RUN, 3, 0, 0, 0, 1);
        add_item(ACT_READ, 15, 0, 0, 0, 0);
        // no active objects: the longest run changes nothing
        add_cfg(CFG_ACTIVE, 0);
        add_item(ACT_RUN, 7, 0, 0, 0, 17'h1FFFF);

        // random phases, each under a fresh register setting
        for (int ph = 0; ph < 4; ph++) begin
            n_obj      = (ph == 3) ? 16 : $urandom_range(2, 6);
            wall_units = $urandom_range(20, 300);
            add_cfg(CFG_ACTIVE, n_obj);
            add_cfg(CFG_TIME_STEP, $urandom_range(32'h0100_0000, 32'hFFFF_FFFF));
            add_cfg(CFG_WALL, fx(wall_units));
            add_cfg(CFG_RESTITUTION, $urandom_range(0, 65536));
            add_cfg(CFG_GRAVITY, $urandom_range(0, 1) ? longint'($urandom)
                                                      : -longint'($urandom));
            add_cfg(CFG_CONTACT, fx($urandom_range(0, 40)) | $urandom);
            random_phase(ph == 3 ? 12 : 26, n_obj, wall_units);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !i_start && expected_q.size() == 0 && !o_busy);
        repeat (20) @(posedge i_clk);
        $display("covered %0d loads, %0d runs, %0d reads, %0d register writes",
                 n_loads, n_runs, n_reads, n_cfg);
        $display("%0d results checked, %0d collisions counted, %0d cycles",
                 n_results, hits, cycles);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("elastic_collision_step_1d_tb: PASS");
        end else begin
            $display("elastic_collision_step_1d_tb: FAIL");
        end
        $finish;
    end

endmodule
